// File: rtl/srgbxyz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbxyz_pkg: shared types, constants and table builder
// Widths of the pixel path, D65 matrix coefficients and the exact sRGB
// linearization entry, evaluated at elaboration to load the lookup memories.
// ----------------------------------------------------------------------------
package srgbxyz_pkg;

	localparam int IN_BITS_DEF = 12;
	localparam int IN_BITS_MAX = 16;
	localparam int LIN_W       = 16;
	localparam int COEF_W      = 15;
	localparam int PROD_W      = LIN_W + COEF_W;
	localparam int ACC_W       = 31;
	localparam int OUT_W       = 15;
	localparam int BIG_W       = 448;

	localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(32768);
	localparam logic [OUT_W-1:0] XYZ_MAX   = OUT_W'(27880);

	// D65 2-degree matrix, scaled by 25600 (rows X, Y, Z; columns R, G, B)
	localparam logic [COEF_W-1:0] COEF [3][3] = '{
		'{COEF_W'(10557), COEF_W'(9155),  COEF_W'(4621)},
		'{COEF_W'(5443),  COEF_W'(18309), COEF_W'(1848)},
		'{COEF_W'(494),   COEF_W'(3052),  COEF_W'(24333)}
	};

	// Write word from the table loader into the lookup memories
	typedef struct packed {
		logic                   en;
		logic [IN_BITS_MAX-1:0] addr;
		logic [LIN_W-1:0]       data;
	} lin_wr_t;

	// Integer power of a wide value
	function automatic logic [BIG_W-1:0] big_pow(input logic [BIG_W-1:0] b, input int e);
		logic [BIG_W-1:0] r;
		r = BIG_W'(1);
		for (int k = 0; k < e; k++) begin
			r = r * b;
		end
		return r;
	endfunction

	// Linearized value of one code in 0.16, rounded to nearest, saturated
	function automatic logic [LIN_W-1:0] lin_entry(input longint unsigned code,
		input int in_bits);
		longint unsigned  m;
		longint unsigned  s;
		longint unsigned  den;
		longint unsigned  lo;
		longint unsigned  hi;
		longint unsigned  mid;
		logic [BIG_W-1:0] dpow;
		logic [BIG_W-1:0] rhs;
		logic [BIG_W-1:0] lhs;
		m  = (64'd1 << in_bits) - 64'd1;
		lo = 64'd0;
		hi = 64'd65536;
		if (code * 64'd100000 > m * 64'd4045) begin
			// power segment: largest n with (2n-1)^5 * d^12 <= 2^85 * s^12
			s    = code * 64'd1000 + m * 64'd55;
			dpow = big_pow(BIG_W'(m * 64'd1055), 12);
			rhs  = big_pow(BIG_W'(s), 12) << 85;
			lo   = 64'd1;
			for (int k = 0; k < 18; k++) begin
				if (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					lhs = dpow * big_pow(BIG_W'(mid * 64'd2 - 64'd1), 5);
					if (lhs <= rhs) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
			end
		end else begin
			// linear segment: largest v with 2*den*v <= 13107200*c + den
			den = m * 64'd1292;
			rhs = BIG_W'(code * 64'd13107200 + den);
			for (int k = 0; k < 18; k++) begin
				if (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					lhs = BIG_W'(mid) * BIG_W'(den * 64'd2);
					if (lhs <= rhs) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
			end
		end
		if (lo > 64'd65535) begin
			lo = 64'd65535;
		end
		return LIN_W'(lo);
	endfunction

endpackage

// File: rtl/srgbxyz_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbxyz_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module srgbxyz_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/srgbxyz_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbxyz_fill: lookup memory loader
// Sweeps every code once after reset and writes its linearized value into
// the lookup memories; holds busy until the last word is written.
// ----------------------------------------------------------------------------
module srgbxyz_fill import srgbxyz_pkg::*; #(
	parameter int IN_BITS = IN_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	output lin_wr_t wr,
	output logic    busy
);

	localparam int DEPTH = 2 ** IN_BITS;

	localparam logic ST_FILL = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic               st_q;
	logic [IN_BITS-1:0] idx_q;
	logic               wr_en_q;
	logic [IN_BITS-1:0] wr_addr_q;
	logic [LIN_W-1:0]   wr_data_q;
	logic [LIN_W-1:0]   lut_w [DEPTH];

	// constant linearization table, worked out at elaboration
	for (genvar g = 0; g < DEPTH; g++) begin : g_lut
		localparam logic [LIN_W-1:0] ENTRY = lin_entry(longint'(g), IN_BITS);
		assign lut_w[g] = ENTRY;
	end

	// advance the sweep, then stay in run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_FILL;
			idx_q   <= '0;
			wr_en_q <= 1'b0;
		end else begin
			case (st_q)
				ST_FILL: begin
					wr_en_q <= 1'b1;
					idx_q   <= idx_q + IN_BITS'(1);
					if (&idx_q) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					wr_en_q <= 1'b0;
				end
				default: begin
					st_q    <= ST_FILL;
					wr_en_q <= 1'b0;
				end
			endcase
		end
	end

	// register the table word ahead of the memory write
	always_ff @(posedge clk) begin
		wr_addr_q <= idx_q;
		wr_data_q <= lut_w[idx_q];
	end

	assign wr.en   = wr_en_q;
	assign wr.addr = IN_BITS_MAX'(wr_addr_q);
	assign wr.data = wr_data_q;
	assign busy    = (st_q == ST_FILL) || wr_en_q;

endmodule

// File: rtl/srgbxyz_mtx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbxyz_mtx: D65 matrix pipeline
// Stage 2 forms the nine coefficient products, stage 3 sums each row with
// rounding; the outputs are taken straight from the stage 3 registers.
// ----------------------------------------------------------------------------
module srgbxyz_mtx import srgbxyz_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [LIN_W-1:0] lin_r,
	input  logic [LIN_W-1:0] lin_g,
	input  logic [LIN_W-1:0] lin_b,
	output logic             done,
	output logic [OUT_W-1:0] x_value,
	output logic [OUT_W-1:0] y_value,
	output logic [OUT_W-1:0] z_value
);

	logic              valid_s2;
	logic              valid_s3;
	logic [LIN_W-1:0]  lin_w  [3];
	logic [PROD_W-1:0] prod_s2 [3][3];
	logic [ACC_W-1:0]  acc_s3 [3];

	assign lin_w[0] = lin_r;
	assign lin_w[1] = lin_g;
	assign lin_w[2] = lin_b;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
		end
	end

	// multiply each linear channel by its coefficient
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[j][i] <= PROD_W'(lin_w[i]) * PROD_W'(COEF[j][i]);
			end
		end
	end

	// sum each row and add the rounding half
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			acc_s3[j] <= ACC_W'(prod_s2[j][0]) + ACC_W'(prod_s2[j][1])
				+ ACC_W'(prod_s2[j][2]) + ROUND_ADD;
		end
	end

	assign done    = valid_s3;
	assign x_value = acc_s3[0][ACC_W-1 -: OUT_W];
	assign y_value = acc_s3[1][ACC_W-1 -: OUT_W];
	assign z_value = acc_s3[2][ACC_W-1 -: OUT_W];

endmodule

// File: rtl/srgb_to_xyz_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_xyz_top: sRGB (D65) to CIE XYZ pixel converter
// Takes one pixel per clock, a word whenever start is high and busy low.
// Each result appears for one cycle with done high, once its word has
// passed the read, product and sum registers; the receiver cannot stall,
// so results must be captured when done is seen. After reset busy stays
// high while the three linearization memories are loaded from the constant
// table, one code per cycle; from then on busy stays low and the rate is
// one pixel per clock, set by the memory read, multiply and sum stages.
// ----------------------------------------------------------------------------
module srgb_to_xyz_top import srgbxyz_pkg::*; #(
	parameter int IN_BITS = IN_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [IN_BITS-1:0] red_code,
	input  logic [IN_BITS-1:0] green_code,
	input  logic [IN_BITS-1:0] blue_code,
	output logic               done,
	output logic [OUT_W-1:0]   x_value,
	output logic [OUT_W-1:0]   y_value,
	output logic [OUT_W-1:0]   z_value
);

	localparam int DEPTH = 2 ** IN_BITS;

	lin_wr_t          fill_wr;
	logic             valid_s1;
	logic [LIN_W-1:0] lin_r_s1;
	logic [LIN_W-1:0] lin_g_s1;
	logic [LIN_W-1:0] lin_b_s1;

	// load the lookup memories after reset
	srgbxyz_fill #(
		.IN_BITS(IN_BITS)
	) u_fill (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (fill_wr),
		.busy  (busy)
	);

	// stage 1: look up each channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	srgbxyz_ram #(
		.WIDTH(LIN_W),
		.DEPTH(DEPTH)
	) u_ram_r (
		.clk  (clk),
		.we   (fill_wr.en),
		.waddr(fill_wr.addr[IN_BITS-1:0]),
		.wdata(fill_wr.data),
		.raddr(red_code),
		.rdata(lin_r_s1)
	);

	srgbxyz_ram #(
		.WIDTH(LIN_W),
		.DEPTH(DEPTH)
	) u_ram_g (
		.clk  (clk),
		.we   (fill_wr.en),
		.waddr(fill_wr.addr[IN_BITS-1:0]),
		.wdata(fill_wr.data),
		.raddr(green_code),
		.rdata(lin_g_s1)
	);

	srgbxyz_ram #(
		.WIDTH(LIN_W),
		.DEPTH(DEPTH)
	) u_ram_b (
		.clk  (clk),
		.we   (fill_wr.en),
		.waddr(fill_wr.addr[IN_BITS-1:0]),
		.wdata(fill_wr.data),
		.raddr(blue_code),
		.rdata(lin_b_s1)
	);

	// stages 2 and 3: matrix
	srgbxyz_mtx u_mtx (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(valid_s1),
		.lin_r   (lin_r_s1),
		.lin_g   (lin_g_s1),
		.lin_b   (lin_b_s1),
		.done    (done),
		.x_value (x_value),
		.y_value (y_value),
		.z_value (z_value)
	);

endmodule

// File: rtl/srgbxyz_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbxyz_chk: port checker for the sRGB to XYZ converter
// Watches the top-level ports for latency, busy behaviour and result range.
// ----------------------------------------------------------------------------
module srgbxyz_chk import srgbxyz_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [OUT_W-1:0] x_value,
	input logic [OUT_W-1:0] y_value,
	input logic [OUT_W-1:0] z_value
);

	// every accepted word yields a result once it has passed the pipeline
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted word produced no result");

	// no result without a matching earlier accepted word
	a_done_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without an accepted word");

	// once the table load is over, busy never returns
	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after table load");

	// results stay within the XYZ range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (x_value <= XYZ_MAX) && (y_value <= XYZ_MAX) && (z_value <= XYZ_MAX))
		else $error("result out of range");

endmodule

bind srgb_to_xyz_top srgbxyz_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.x_value(x_value),
	.y_value(y_value),
	.z_value(z_value)
);

// File: dv/srgb_to_xyz_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_xyz_top_test: pixel-level test of the sRGB to CIE XYZ converter
// Builds an exact linearization table on its own, feeds corner pixels, a
// full-rate run and bursts with random gaps, predicts each XYZ word and checks
// every done strobe in the order the pixels were taken.
// ----------------------------------------------------------------------------
module srgb_to_xyz_top_test import srgbxyz_pkg::*;;

	localparam int CODE_W       = IN_BITS_DEF;
	localparam int CODE_TOP     = (1 << CODE_W) - 1;
	localparam int WIDE_W       = 448;
	localparam int RANDOM_WORDS = 820;
	localparam int DRAIN_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 16;

	typedef logic [WIDE_W-1:0] wide_t;
	typedef logic [CODE_W-1:0] code_t;

	typedef struct {
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] z;
	} xyz_word_t;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             start      = 1'b0;
	code_t            red_code   = '0;
	code_t            green_code = '0;
	code_t            blue_code  = '0;
	logic             busy;
	logic             done;
	logic [OUT_W-1:0] x_value;
	logic [OUT_W-1:0] y_value;
	logic [OUT_W-1:0] z_value;

	logic [LIN_W-1:0] linear_lut [0:CODE_TOP];
	xyz_word_t        pending_xyz [$];
	int unsigned      mismatches = 0;

	srgb_to_xyz_top #(
		.IN_BITS(CODE_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red_code  (red_code),
		.green_code(green_code),
		.blue_code (blue_code),
		.done      (done),
		.x_value   (x_value),
		.y_value   (y_value),
		.z_value   (z_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Integer power on a wide vector
	function automatic wide_t wide_power(input wide_t base, input int n);
		wide_t acc;
		acc = wide_t'(1);
		for (int k = 0; k < n; k++) begin
			acc = acc * base;
		end
		return acc;
	endfunction

	// True when n is not above the exactly rounded 0.16 power value
	function automatic bit power_fits(input longint unsigned n, input wide_t dpow,
		input wide_t spow);
		return (wide_power(wide_t'(2 * n - 1), 5) * dpow) <= spow;
	endfunction

	// Linear light of one code in 0.16, rounded to nearest, saturated
	function automatic logic [LIN_W-1:0] linearize(input int unsigned code);
		longint unsigned m;
		longint unsigned den;
		longint unsigned est;
		wide_t           dpow;
		wide_t           spow;
		real             v;
		m = CODE_TOP;
		if (64'(code) * 64'd100000 > m * 64'd4045) begin
			// start from a float estimate, then settle it on the exact bound
			v    = (real'(code) / real'(m) + 0.055) / 1.055;
			est  = $rtoi(65536.0 * $pow(v, 2.4) + 0.5);
			dpow = wide_power(wide_t'(m * 64'd1055), 12);
			spow = wide_power(wide_t'(64'(code) * 64'd1000 + m * 64'd55), 12) << 85;
			if (est < 1) begin
				est = 1;
			end
			if (est > 65536) begin
				est = 65536;
			end
			while (est < 65536 && power_fits(est + 1, dpow, spow)) begin
				est++;
			end
			while (est > 1 && !power_fits(est, dpow, spow)) begin
				est--;
			end
		end else begin
			// straight segment, divide by 12.92 with round half up
			den = m * 64'd1292;
			est = (64'(code) * 64'd13107200 + den) / (2 * den);
		end
		if (est > 65535) begin
			est = 65535;
		end
		return LIN_W'(est);
	endfunction

	// Apply the D65 matrix to the linearized channels
	function automatic xyz_word_t predict_xyz(input code_t r, input code_t g, input code_t b);
		longint unsigned lr;
		longint unsigned lg;
		longint unsigned lb;
		xyz_word_t       w;
		lr  = linear_lut[r];
		lg  = linear_lut[g];
		lb  = linear_lut[b];
		w.x = OUT_W'((lr * 10557 + lg * 9155 + lb * 4621 + 32768) >> 16);
		w.y = OUT_W'((lr * 5443 + lg * 18309 + lb * 1848 + 32768) >> 16);
		w.z = OUT_W'((lr * 494 + lg * 3052 + lb * 24333 + 32768) >> 16);
		return w;
	endfunction

	// Bias toward the ends of the range and the segment boundary
	function automatic code_t random_code();
		case ($urandom_range(0, 7))
			0: begin
				return code_t'($urandom_range(0, 3));
			end
			1: begin
				return code_t'(CODE_TOP - $urandom_range(0, 3));
			end
			2: begin
				return code_t'($urandom_range(160, 172));
			end
			default: begin
				return code_t'($urandom);
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Present one pixel word and hold it until it is taken
	task automatic send_pixel(input code_t r, input code_t g, input code_t b);
		@(negedge clk);
		start      <= 1'b1;
		red_code   <= r;
		green_code <= g;
		blue_code  <= b;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
	endtask

	// Drop start, with junk on the channel ports
	task automatic idle_cycles(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start      <= 1'b0;
			red_code   <= code_t'($urandom);
			green_code <= code_t'($urandom);
			blue_code  <= code_t'($urandom);
		end
	endtask

	task automatic send_random_pixel();
		send_pixel(random_code(), random_code(), random_code());
	endtask

	// Black, white, primaries and secondaries, the segment boundary, near-end codes, midscale and alternating bits
	task automatic test_corner_pixels();
		code_t lo;
		code_t hi;
		lo = '0;
		hi = code_t'(CODE_TOP);
		send_pixel(lo, lo, lo);
		send_pixel(hi, hi, hi);
		send_pixel(hi, lo, lo);
		send_pixel(lo, hi, lo);
		send_pixel(lo, lo, hi);
		send_pixel(hi, hi, lo);
		send_pixel(lo, hi, hi);
		send_pixel(hi, lo, hi);
		send_pixel(code_t'(165), code_t'(165), code_t'(165));
		send_pixel(code_t'(166), code_t'(166), code_t'(166));
		send_pixel(code_t'(165), code_t'(166), code_t'(1));
		send_pixel(code_t'(1), code_t'(1), code_t'(1));
		send_pixel(code_t'(CODE_TOP - 1), code_t'(CODE_TOP - 1), code_t'(CODE_TOP - 1));
		send_pixel(code_t'(2048), code_t'(2048), code_t'(2048));
		send_pixel(hi, code_t'(165), code_t'(166));
		send_pixel(12'hAAA, 12'h555, 12'hAAA);
		send_pixel(12'h555, 12'hAAA, 12'h555);
		idle_cycles(3);
	endtask

	// One word per clock with no gaps
	task automatic test_full_rate();
		repeat (64) begin
			send_random_pixel();
		end
		idle_cycles(1);
	endtask

	// Bursts of random length separated by random gaps
	task automatic test_random_bursts();
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				send_random_pixel();
				sent++;
			end
			if ($urandom_range(0, 9) == 0) begin
				gap = $urandom_range(20, 40);
			end else begin
				gap = $urandom_range(0, 6);
			end
			if (gap != 0) begin
				idle_cycles(gap);
			end
		end
		idle_cycles(1);
	endtask

	// Check each done word, then queue the prediction for a word taken now
	always @(posedge clk) begin : xyz_monitor
		xyz_word_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_xyz.size() == 0) begin
					$display("%0t ns: no word expected, actual x %0d y %0d z %0d",
						$time, x_value, y_value, z_value);
					mismatches++;
				end else begin
					want = pending_xyz.pop_front();
					check_field("x_value", want.x, x_value);
					check_field("y_value", want.y, y_value);
					check_field("z_value", want.z, z_value);
				end
			end else if (done !== 1'b0) begin
				$display("%0t ns: done expected 0 or 1, actual %b", $time, done);
				mismatches++;
			end
			if (start && busy === 1'b0) begin
				pending_xyz.push_back(predict_xyz(red_code, green_code, blue_code));
			end
		end
	end

	initial begin
		for (int c = 0; c <= CODE_TOP; c++) begin
			linear_lut[c] = linearize(c);
		end
		repeat (9) begin
			@(posedge clk);
		end
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_pixels();
		test_full_rate();
		test_random_bursts();

		// drain the pipeline, then let the clock run on for an idle tail
		for (int k = 0; k < DRAIN_LIMIT && pending_xyz.size() != 0; k++) begin
			@(posedge clk);
		end
		if (pending_xyz.size() != 0) begin
			$display("%0t ns: words expected 0 outstanding, actual %0d", $time,
				pending_xyz.size());
			mismatches += pending_xyz.size();
		end
		repeat (TAIL_CYCLES) begin
			@(posedge clk);
		end

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Hard stop well beyond the longest correct run
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
